[rtl/tdfs_pkg.sv]
package tdfs_pkg;

	// Width of the clock ratio, the target and the prescaler.
	localparam int unsigned DATA_W = 30;
	// Width of the timer period field.
	localparam int unsigned PER_W = 16;
	// Width of the trial divisor; it never passes sqrt(2^30) = 32768.
	localparam int unsigned TRIAL_W = 16;
	localparam int unsigned STATUS_W = 2;

	localparam logic [PER_W-1:0] PERIOD_LIMIT = 16'hFFFF;
	localparam logic [DATA_W-1:0] MIN_RATIO = 30'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LOW_RATIO = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_TARGET = 2'd2;

	localparam logic [DATA_W-1:0] SYS_CLOCK_RESET = 30'd72000000;

	// Byte address 4 * index of the only register.
	localparam logic [0:0] REG_SYS_CLOCK = 1'b0;

endpackage

[rtl/tdfs_div.sv]
module tdfs_div import tdfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient,
	output logic [DATA_W-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;

	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	logic            fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[rtl/timer_divider_factor_solver_unit.sv]
// Timer divider factor solver. For each target frequency item the block
// forms q = sys_clock_hz / target_freq and returns a prescaler and a period
// whose product divides q, with the period below 0xFFFF; a zero target gives
// status 2 and a ratio below two gives status 1, both with zero fields. All
// divisions run through one shared 30-bit restoring divider that retires
// one quotient bit a cycle. Seen from the sequencer a division goes through
// these steps: the request is registered, the divider loads it, runs 30 bit
// steps, and raises its done flag. Each trial divisor costs one division
// plus the S_SQ and S_CMP bookkeeping states, and each prescaler update
// costs about the same. A largest-prime search tries divisors up to the
// square root of its operand, at most about 32767 of them.
// The block takes one item at a time: in_stall is high from acceptance until
// the result is moved into the output register, which may still hold the
// previous result while the next item is accepted. sys_clock_hz is written at
// byte address 0 of the APB port and resets to 72000000.
module timer_divider_factor_solver_unit import tdfs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Input item channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [DATA_W-1:0]   target_freq,
	// Result item channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PER_W-1:0]    period,
	output logic [DATA_W-1:0]   prescaler,
	output logic [STATUS_W-1:0] status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_QDIV = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_TDIV = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_PDIV = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;

	logic [DATA_W-1:0] sys_clock_q;

	// Solver registers.
	logic [DATA_W-1:0]   ratio_q;   // q
	logic [DATA_W-1:0]   num_q;     // operand of the current prime search
	logic [TRIAL_W-1:0]  trial_q;   // current trial divisor
	logic [2*TRIAL_W-1:0] sq_q;     // trial divisor squared
	logic [DATA_W-1:0]   pre_q;     // prescaler so far
	logic [DATA_W-1:0]   prod_q;    // prescaler times new prime factor
	logic                first_q;   // searching the factor of q itself

	logic [PER_W-1:0]    res_per_q;
	logic [DATA_W-1:0]   res_pre_q;
	logic [STATUS_W-1:0] res_st_q;

	logic [PER_W-1:0]    period_q;
	logic [DATA_W-1:0]   prescaler_q;
	logic [STATUS_W-1:0] status_q;
	logic                out_valid_q;

	// Divider request, registered so the divider sees stable operands.
	logic              div_go_q;
	logic [DATA_W-1:0] div_a_q;
	logic [DATA_W-1:0] div_b_q;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic [DATA_W-1:0] div_rem;

	logic                 in_take;
	logic                 out_free;
	logic                 cfg_write;
	logic [2*DATA_W-1:0]  prod_full;

	tdfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go_q),
		.dividend  (div_a_q),
		.divisor   (div_b_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Configuration register. Reads return the clock value at address 0.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SYS_CLOCK);
	assign prdata    = (paddr[2] == REG_SYS_CLOCK) ? {2'b00, sys_clock_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_clock_q <= SYS_CLOCK_RESET;
		end else if (cfg_write) begin
			sys_clock_q <= pwdata[DATA_W-1:0];
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign prod_full = pre_q * num_q;

	// Sequencer. Each prime search walks the trial divisor upward, dividing
	// out every factor it finds; whatever remains when the square of the
	// divisor passes the operand is its largest prime factor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (target_freq == '0) begin
							state_q <= S_FIN;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_QDIV;
						end
					end
				end
				S_QDIV: begin
					if (div_done) begin
						state_q <= (div_quo < MIN_RATIO) ? S_FIN : S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (sq_q <= {2'b00, num_q}) begin
						div_go_q <= 1'b1;
						state_q  <= S_TDIV;
					end else if (first_q) begin
						div_go_q <= 1'b1;
						state_q  <= S_PDIV;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						state_q <= S_SQ;
					end
				end
				S_MUL: begin
					div_go_q <= 1'b1;
					state_q  <= S_PDIV;
				end
				S_PDIV: begin
					if (div_done) begin
						state_q <= (div_quo >= {14'd0, PERIOD_LIMIT}) ? S_SQ : S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				div_a_q   <= sys_clock_q;
				div_b_q   <= target_freq;
				res_per_q <= '0;
				res_pre_q <= '0;
				res_st_q  <= STATUS_ZERO_TARGET;
			end
			S_QDIV: begin
				ratio_q  <= div_quo;
				num_q    <= div_quo;
				trial_q  <= TRIAL_W'(2);
				first_q  <= 1'b1;
				res_st_q <= STATUS_LOW_RATIO;
			end
			S_SQ: begin
				sq_q    <= trial_q * trial_q;
				div_a_q <= num_q;
				div_b_q <= {{(DATA_W-TRIAL_W){1'b0}}, trial_q};
			end
			S_CMP: begin
				prod_q <= prod_full[DATA_W-1:0];
				if (sq_q > {2'b00, num_q} && first_q) begin
					pre_q   <= num_q;
					div_a_q <= ratio_q;
					div_b_q <= num_q;
				end
			end
			S_TDIV: begin
				if (div_done) begin
					if (div_rem == '0) begin
						num_q <= div_quo;
					end else begin
						trial_q <= trial_q + 1'b1;
					end
				end
			end
			S_MUL: begin
				pre_q   <= prod_q;
				div_a_q <= ratio_q;
				div_b_q <= prod_q;
			end
			S_PDIV: begin
				if (div_done) begin
					num_q     <= div_quo;
					trial_q   <= TRIAL_W'(2);
					first_q   <= 1'b0;
					res_per_q <= div_quo[PER_W-1:0];
					res_pre_q <= pre_q;
					res_st_q  <= STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			period_q    <= res_per_q;
			prescaler_q <= res_pre_q;
			status_q    <= res_st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign period    = period_q;
	assign prescaler = prescaler_q;
	assign status    = status_q;

endmodule
